// File: rtl/core/ss_pkg.sv
// shared types and codes for the sorted set engine
// no dependencies; imported by ss_step, sorted_set_engine_core and the testbench
package ss_pkg;

  // request kinds
  localparam logic [1:0] KIND_MEMBER = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  // source of a memory write
  localparam logic [1:0] SRC_KEY   = 2'd0;
  localparam logic [1:0] SRC_CARRY = 2'd1;
  localparam logic [1:0] SRC_DATA  = 2'd2;

  // decision for one scan step, from ss_step to the core
  typedef struct packed {
    logic       finish;
    logic       success;
    logic       full;
    logic       wr;
    logic       wr_prev;
    logic [1:0] wr_src;
    logic       set_flag;
    logic       inc;
    logic       dec;
  } step_t;

endpackage

// File: rtl/core/ss_step.sv
// per-entry decision of the sorted set scan: compare, shift and finish
// depends on ss_pkg
module ss_step import ss_pkg::*; (
  input  logic [1:0]  kind,
  input  logic [15:0] key,
  input  logic [15:0] data,
  input  logic        flag,
  input  logic        can_grow,
  input  logic        at_end,
  input  logic        dvalid,
  output step_t       step
);

  logic eq;
  logic gt;

  assign eq = (data == key);
  assign gt = (data > key);

  always_comb begin
    step = '0;
    case (kind)
      KIND_MEMBER: begin
        if (at_end) begin
          step.finish = 1'b1;
        end else if (dvalid) begin
          if (eq) begin
            step.finish  = 1'b1;
            step.success = 1'b1;
          end else if (gt) begin
            step.finish = 1'b1;
          end
        end
      end
      KIND_INSERT: begin
        if (at_end) begin
          step.finish = 1'b1;
          if (flag) begin
            // last shifted entry lands at the old end
            step.wr      = 1'b1;
            step.wr_src  = SRC_CARRY;
            step.inc     = 1'b1;
            step.success = 1'b1;
          end else if (can_grow) begin
            // key is above every held value
            step.wr      = 1'b1;
            step.wr_src  = SRC_KEY;
            step.inc     = 1'b1;
            step.success = 1'b1;
          end else begin
            step.full = 1'b1;
          end
        end else if (dvalid) begin
          if (!flag) begin
            if (eq) begin
              step.finish = 1'b1;
            end else if (gt) begin
              if (can_grow) begin
                step.wr       = 1'b1;
                step.wr_src   = SRC_KEY;
                step.set_flag = 1'b1;
              end else begin
                step.finish = 1'b1;
                step.full   = 1'b1;
              end
            end
          end else begin
            step.wr     = 1'b1;
            step.wr_src = SRC_CARRY;
          end
        end
      end
      KIND_DELETE: begin
        if (at_end) begin
          step.finish = 1'b1;
          if (flag) begin
            step.dec     = 1'b1;
            step.success = 1'b1;
          end
        end else if (dvalid) begin
          if (!flag) begin
            if (eq) begin
              step.set_flag = 1'b1;
            end else if (gt) begin
              step.finish = 1'b1;
            end
          end else begin
            // close the gap: move entry down by one
            step.wr      = 1'b1;
            step.wr_prev = 1'b1;
            step.wr_src  = SRC_DATA;
          end
        end
      end
      default: begin
        step.finish = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/core/sorted_set_engine_core.sv
// one request at a time; busy stays high until the cycle done is shown, so a new
// request waits for the single scan over the value ram to finish
// results are never stalled; done is high for exactly one cycle
// rst (synchronous) empties the set; ram contents are not cleared
module sorted_set_engine_core import ss_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  kind,
  input  logic [15:0] key_value,
  output logic        busy,
  output logic        done,
  output logic        success,
  output logic        store_full,
  output logic [8:0]  entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // control state
  logic          state;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] di;        // index of the entry whose read data is arriving
  logic [CW-1:0] rd_idx;    // index being read this cycle
  logic          dvalid;    // rd_data holds entry di
  logic          flag;      // insert: key placed; delete: match found

  // payload
  logic [1:0]    op_kind;
  logic [15:0]   op_key;
  logic [15:0]   carry;     // entry displaced by an insert shift
  logic [15:0]   rd_data;
  logic [15:0]   wr_data;
  logic [AW-1:0] wr_addr;
  logic          at_end;
  logic          can_grow;
  step_t         step;

  // sorted value ram, one read and one write port, registered read
  logic [15:0]   mem [CAPACITY];

  assign busy     = (state == ST_SCAN);
  assign at_end   = (di == count);
  assign can_grow = (count < CW'(CAPACITY));

  ss_step u_step (
    .kind     (op_kind),
    .key      (op_key),
    .data     (rd_data),
    .flag     (flag),
    .can_grow (can_grow),
    .at_end   (at_end),
    .dvalid   (dvalid),
    .step     (step)
  );

  // count after this step
  always_comb begin
    count_next = count;
    if (step.inc) begin
      count_next = count + CW'(1);
    end else if (step.dec) begin
      count_next = count - CW'(1);
    end
  end

  // write data and address; the read in flight targets di + 1, so a write
  // at di or di - 1 never meets it and needs no forwarding
  always_comb begin
    case (step.wr_src)
      SRC_KEY:   wr_data = op_key;
      SRC_CARRY: wr_data = carry;
      SRC_DATA:  wr_data = rd_data;
      default:   wr_data = op_key;
    endcase
    wr_addr = step.wr_prev ? (di[AW-1:0] - AW'(1)) : di[AW-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      count  <= '0;
      di     <= '0;
      rd_idx <= '0;
      dvalid <= 1'b0;
      flag   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            di     <= '0;
            rd_idx <= '0;
            dvalid <= 1'b0;
            flag   <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_idx <= rd_idx + CW'(1);
          dvalid <= 1'b1;
          count  <= count_next;
          if (step.set_flag) begin
            flag <= 1'b1;
          end
          if (dvalid && !at_end) begin
            di <= di + CW'(1);
          end
          if (step.finish) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // request capture, carry and result registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op_kind <= kind;
      op_key  <= key_value;
    end
    if (state == ST_SCAN && dvalid && !at_end) begin
      carry <= rd_data;
    end
    if (state == ST_SCAN && step.finish) begin
      success     <= step.success;
      store_full  <= step.full;
      entry_count <= 9'(count_next);
    end
  end

  // ram ports
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx[AW-1:0]];
    if (state == ST_SCAN && step.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// File: rtl/core/ss_chk.sv
// port-level checks for the sorted set engine core
// depends on sorted_set_engine_core; attached by the bind below
module ss_chk #(
  parameter int CAPACITY = 256
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        success,
  input logic        store_full,
  input logic [8:0]  entry_count
);

  // a refused insert never also reports success
  a_full_excl: assert property (@(posedge clk) disable iff (rst)
    (done && store_full) |-> !success)
    else $error("store_full with success");

  // a refused insert only happens at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && store_full) |-> (entry_count == 9'(CAPACITY)))
    else $error("store_full below capacity");

  // an accepted request keeps the engine busy in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // a result follows work in progress
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("done without a request in flight");

  // reset leaves the engine idle with no strobe
  a_reset: assert property (@(posedge clk)
    rst |=> (!done && !busy))
    else $error("not idle after reset");

endmodule

bind sorted_set_engine_core ss_chk #(.CAPACITY(CAPACITY)) u_ss_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .success     (success),
  .store_full  (store_full),
  .entry_count (entry_count)
);

// File: tb/sv/sorted_set_engine_core_tb.sv
// testbench for sorted_set_engine_core: member, insert and delete requests
// checked against a sorted-array predictor; depends on ss_pkg and the core only
`timescale 1ns / 100ps

module sorted_set_engine_core_tb;
  import ss_pkg::*;

  localparam int CAPACITY = 256;
  // kind code the block treats as a no-op
  localparam logic [1:0] KIND_NOP = 2'd3;
  // worst quiet stretch is the longest idle gap plus a full scan; take it several times over
  localparam int WATCHDOG_LIMIT = 2000;
  // cycles to keep watching for stray done strobes once everything has arrived
  localparam int DRAIN_CYCLES = CAPACITY + 40;
  localparam int POOL_SIZE = 24;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] key;
    int          gap;   // idle cycles after this request is accepted
  } request_t;

  typedef struct packed {
    logic       success;
    logic       store_full;
    logic [8:0] entry_count;
  } set_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  kind = KIND_MEMBER;
  logic [15:0] key_value = 16'h0000;
  logic        busy;
  logic        done;
  logic        success;
  logic        store_full;
  logic [8:0]  entry_count;

  sorted_set_engine_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .kind(kind),
    .key_value(key_value),
    .busy(busy),
    .done(done),
    .success(success),
    .store_full(store_full),
    .entry_count(entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: a plain ascending array plus a count
  // ---------------------------------------------------------------------------
  logic [15:0] shadow_vals [CAPACITY];
  int unsigned shadow_count = 0;

  function automatic set_result_t apply_request(logic [1:0] op, logic [15:0] key);
    set_result_t r;
    int unsigned pos;
    bit present;
    r = '0;
    pos = 0;
    // first slot whose value is not below the key
    while (pos < shadow_count && shadow_vals[pos] < key) pos++;
    present = (pos < shadow_count) && (shadow_vals[pos] == key);
    case (op)
      KIND_MEMBER: begin
        r.success = present;
      end
      KIND_INSERT: begin
        // presence check comes first, so a duplicate never reports full
        if (!present) begin
          if (shadow_count >= CAPACITY) begin
            r.store_full = 1'b1;
          end else begin
            for (int j = shadow_count; j > pos; j--) shadow_vals[j] = shadow_vals[j - 1];
            shadow_vals[pos] = key;
            shadow_count++;
            r.success = 1'b1;
          end
        end
      end
      KIND_DELETE: begin
        // exact match only; close the gap behind the removed entry
        if (present) begin
          for (int j = pos; j + 1 < shadow_count; j++) shadow_vals[j] = shadow_vals[j + 1];
          shadow_count--;
          r.success = 1'b1;
        end
      end
      default: begin
        // unused kind: nothing changes, count still shown
      end
    endcase
    r.entry_count = shadow_count[8:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request generation
  // ---------------------------------------------------------------------------
  request_t    pending_reqs[$];
  set_result_t expected_results[$];
  logic [15:0] key_pool [POOL_SIZE];
  logic [15:0] fill_keys [CAPACITY];
  int          slot_order [CAPACITY];
  int          quiet_left = 0;   // requests left in a stretch with no idling
  bit          tail_mode = 1'b0; // last part of the run: no idling at all

  task automatic push_request(logic [1:0] op, logic [15:0] key);
    request_t req;
    req.kind = op;
    req.key = key;
    req.gap = 0;
    if (!tail_mode) begin
      if (quiet_left > 0) begin
        quiet_left--;
      end else if ($urandom_range(0, 29) == 0) begin
        quiet_left = $urandom_range(10, 40);
      end else if ($urandom_range(0, 2) == 0) begin
        req.gap = $urandom_range(1, 18);
      end
    end
    pending_reqs.push_back(req);
  endtask

  // random mix over a small key pool so hits and misses both come often;
  // inserts stay inside the pool so the set can be emptied again later
  task automatic random_pool_phase(int count);
    int pick;
    logic [15:0] key;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 15);
      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick >= 5 && pick <= 10) begin
        push_request(KIND_INSERT, key);
      end else begin
        if ($urandom_range(0, 7) == 0) key = 16'($urandom_range(0, 65535));
        if (pick <= 4) push_request(KIND_MEMBER, key);
        else if (pick <= 14) push_request(KIND_DELETE, key);
        else push_request(KIND_NOP, key);
      end
    end
  endtask

  task automatic shuffle_slots();
    int j;
    int tmp;
    for (int i = CAPACITY - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = slot_order[i];
      slot_order[i] = slot_order[j];
      slot_order[j] = tmp;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one request at a time, held until the block takes it
  // ---------------------------------------------------------------------------
  int       gap_left = 0;
  request_t launch_req;
  int       accepted_reqs = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_request(kind, key_value));
        accepted_reqs++;
      end
      // free to present something new when nothing is waiting or it was just taken
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          launch_req = pending_reqs.pop_front();
          start <= 1'b1;
          kind <= launch_req.kind;
          key_value <= launch_req.key;
          gap_left = launch_req.gap;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and watchdog
  // ---------------------------------------------------------------------------
  int          error_count = 0;
  int          result_num = 0;
  int          quiet_cycles = 0;
  set_result_t want;

  task automatic report_mismatch(string what, int got, int exp_val);
    if (error_count < 200)
      $display("mismatch at result %0d: %s got %0d expected %0d",
               result_num, what, got, exp_val);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch("done with no request waiting", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (success !== want.success)
            report_mismatch("success", success, want.success);
          if (store_full !== want.store_full)
            report_mismatch("store_full", store_full, want.store_full);
          if (entry_count !== want.entry_count)
            report_mismatch("entry_count", entry_count, want.entry_count);
        end
        result_num++;
      end
      if (done || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int k0;
    int r;

    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'h5555;
    key_pool[3] = 16'hAAAA;
    key_pool[4] = 16'h8000;
    key_pool[5] = 16'h7FFF;
    for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom_range(0, 65535));

    // directed: empty store, extremes, duplicates, misses, unused kind
    push_request(KIND_MEMBER, 16'h0000);   // member on empty
    push_request(KIND_DELETE, 16'hFFFF);   // delete on empty
    push_request(KIND_NOP,    16'h1234);   // unused kind on empty
    push_request(KIND_INSERT, 16'h8000);
    push_request(KIND_INSERT, 16'h0000);   // goes to the front
    push_request(KIND_INSERT, 16'hFFFF);   // goes to the end
    push_request(KIND_INSERT, 16'h4000);   // goes in the middle
    push_request(KIND_INSERT, 16'h8000);   // duplicate insert
    push_request(KIND_MEMBER, 16'h8000);
    push_request(KIND_MEMBER, 16'h8001);   // near miss
    push_request(KIND_MEMBER, 16'hFFFF);
    push_request(KIND_DELETE, 16'h4001);   // delete of an absent value
    push_request(KIND_DELETE, 16'h0000);   // first entry
    push_request(KIND_DELETE, 16'hFFFF);   // last entry
    push_request(KIND_NOP,    16'hFFFF);   // unused kind shows the count
    push_request(KIND_DELETE, 16'h8000);
    push_request(KIND_DELETE, 16'h4000);   // back to empty
    push_request(KIND_DELETE, 16'h4000);
    push_request(KIND_INSERT, 16'h5555);
    push_request(KIND_INSERT, 16'hAAAA);
    push_request(KIND_MEMBER, 16'hAAAA);
    push_request(KIND_NOP,    16'h0000);

    random_pool_phase(400);

    // empty the set so the fill below reaches exactly CAPACITY
    for (int i = 0; i < POOL_SIZE; i++) push_request(KIND_DELETE, key_pool[i]);

    // fill with distinct keys: the high byte is unique per entry, in random order
    for (int i = 0; i < CAPACITY; i++) begin
      fill_keys[i] = {i[7:0], 8'($urandom_range(0, 255))};
      slot_order[i] = i;
    end
    shuffle_slots();
    for (int i = 0; i < CAPACITY; i++) push_request(KIND_INSERT, fill_keys[slot_order[i]]);

    // full store: absent inserts refused with the full flag, duplicates not
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(0, CAPACITY - 1);
      push_request(KIND_INSERT, fill_keys[r] ^ 16'h0001);
    end
    for (int i = 0; i < 3; i++)
      push_request(KIND_INSERT, fill_keys[$urandom_range(0, CAPACITY - 1)]);
    push_request(KIND_MEMBER, fill_keys[$urandom_range(0, CAPACITY - 1)]);
    push_request(KIND_MEMBER, fill_keys[CAPACITY - 1]);
    push_request(KIND_MEMBER, fill_keys[0] ^ 16'h0080);
    push_request(KIND_NOP, fill_keys[7]);
    k0 = $urandom_range(0, CAPACITY - 1);
    push_request(KIND_DELETE, fill_keys[k0]);
    push_request(KIND_MEMBER, fill_keys[k0]);
    push_request(KIND_INSERT, fill_keys[k0]);          // room again, fills it back up
    push_request(KIND_INSERT, fill_keys[k0] ^ 16'h0002);
    push_request(KIND_INSERT, fill_keys[0] ^ 16'h0001);
    push_request(KIND_INSERT, fill_keys[CAPACITY - 1] ^ 16'h0001);
    push_request(KIND_DELETE, fill_keys[5] ^ 16'h0001);

    // drain in another order, with misses along the way
    shuffle_slots();
    for (int i = 0; i < CAPACITY; i++) begin
      push_request(KIND_DELETE, fill_keys[slot_order[i]]);
      if (i % 64 == 13) push_request(KIND_DELETE, fill_keys[slot_order[i]]);
    end
    push_request(KIND_MEMBER, fill_keys[k0]);

    random_pool_phase(30);
    tail_mode = 1'b1;
    random_pool_phase(150);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ss_pkg.sv
rtl/core/ss_step.sv
rtl/core/sorted_set_engine_core.sv
rtl/core/ss_chk.sv
tb/sv/sorted_set_engine_core_tb.sv
